### rtl/core/iia_pkg.sv
// ----------------------------------------------------------------------------
// Iterative integer ALU package
// Opcodes, controller states and the command and status bundles that link
// the controller with the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package iia_pkg;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_PRIME,
    OP_FACT,
    OP_POW
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL_WAIT,
    ST_DIV_WAIT,
    ST_PRIME_START,
    ST_PRIME_WAIT,
    ST_FACT_START,
    ST_FACT_WAIT,
    ST_POW_CHECK,
    ST_POW_MUL_WAIT,
    ST_POW_SQ_START,
    ST_POW_SQ_WAIT,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_SUB,
    ACC_ZERO,
    ACC_ONE,
    ACC_ALL_ONES,
    ACC_PROD,
    ACC_QUO,
    ACC_REM,
    ACC_DIVZ
  } acc_op_e;

  typedef enum logic [1:0] {
    MUL_A_B,
    MUL_ACC_CNT,
    MUL_ACC_A,
    MUL_A_A
  } mul_sel_e;

  typedef enum logic {
    DIV_B,
    DIV_CNT
  } div_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_TWO,
    CNT_INC
  } cnt_op_e;

  typedef struct packed {
    logic     load;
    acc_op_e  acc_op;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    cnt_op_e  cnt_op;
    logic     a_square;
    logic     b_shift;
  } cmd_t;

  typedef struct packed {
    logic a_le_one;
    logic a_is_one;
    logic a_is_neg_one;
    logic b_zero;
    logic b_neg;
    logic b_odd;
    logic mul_done;
    logic div_done;
    logic prime_stop;
    logic rem_zero;
    logic prod_zero;
    logic cnt_eq_a;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/iia_mul.sv
// ----------------------------------------------------------------------------
// Iterative multiplier
// Shift-and-add multiplier that keeps the low product bits. It takes one
// multiplier bit per cycle and stops as soon as the remaining bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module iia_mul #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DATA_WIDTH-1:0] mcand_i,
  input  wire logic [DATA_WIDTH-1:0] mplier_i,
  output logic                       done_o,
  output logic [DATA_WIDTH-1:0]      prod_o
);

  logic                  busy_q;
  logic [DATA_WIDTH-1:0] mcand_q;
  logic [DATA_WIDTH-1:0] mplier_q;
  logic [DATA_WIDTH-1:0] prod_q;

  assign done_o = busy_q && (mplier_q == '0);
  assign prod_o = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      prod_q   <= '0;
    end else if (busy_q && (mplier_q != '0)) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= {mcand_q[DATA_WIDTH-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[DATA_WIDTH-1:1]};
    end
  end

endmodule

`default_nettype wire

### rtl/core/iia_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider that produces one quotient bit per cycle and
// leaves the quotient and the remainder in its registers.
// ----------------------------------------------------------------------------
`default_nettype none

module iia_div #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DATA_WIDTH-1:0] dividend_i,
  input  wire logic [DATA_WIDTH-1:0] divisor_i,
  output logic                       done_o,
  output logic [DATA_WIDTH-1:0]      quo_o,
  output logic [DATA_WIDTH-1:0]      rem_o
);

  localparam int CntW = $clog2(DATA_WIDTH + 1);

  logic                  busy_q;
  logic [CntW-1:0]       cnt_q;
  logic [DATA_WIDTH-1:0] rem_q;
  logic [DATA_WIDTH-1:0] quo_q;
  logic [DATA_WIDTH-1:0] dvs_q;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  assign trial  = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign ge     = trial >= {1'b0, dvs_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DATA_WIDTH);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      quo_q <= {quo_q[DATA_WIDTH-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/core/iia_datapath.sv
// ----------------------------------------------------------------------------
// Iterative integer ALU datapath
// Operand, accumulator and counter registers around one shared multiplier
// and one shared divider, driven by the controller's command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module iia_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [DATA_WIDTH-1:0] operand_a_i,
  input  wire logic [DATA_WIDTH-1:0] operand_b_i,
  input  wire iia_pkg::cmd_t         cmd_i,
  output iia_pkg::sts_t              sts_o,
  output logic [DATA_WIDTH-1:0]      result_o,
  output logic                       status_o
);

  logic [DATA_WIDTH-1:0] a_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic [DATA_WIDTH-1:0] acc_q;
  logic [DATA_WIDTH-1:0] cnt_q;
  logic                  st_q;

  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH-1:0] mcand;
  logic [DATA_WIDTH-1:0] mplier;
  logic [DATA_WIDTH-1:0] divisor;
  logic [DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] rem;
  logic                  mul_done;
  logic                  div_done;

  assign mag_a = a_q[DATA_WIDTH-1] ? ('0 - a_q) : a_q;
  assign mag_b = b_q[DATA_WIDTH-1] ? ('0 - b_q) : b_q;

  always_comb begin
    case (cmd_i.mul_sel)
      iia_pkg::MUL_A_B: begin
        mcand  = a_q;
        mplier = b_q;
      end
      iia_pkg::MUL_ACC_CNT: begin
        mcand  = acc_q;
        mplier = cnt_q;
      end
      iia_pkg::MUL_ACC_A: begin
        mcand  = acc_q;
        mplier = a_q;
      end
      default: begin
        mcand  = a_q;
        mplier = a_q;
      end
    endcase
  end

  assign divisor = (cmd_i.div_sel == iia_pkg::DIV_CNT) ? cnt_q : mag_b;

  iia_mul #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .done_o   (mul_done),
    .prod_o   (prod)
  );

  iia_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag_a),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q  <= operand_a_i;
      b_q  <= operand_b_i;
      st_q <= 1'b0;
    end else begin
      if (cmd_i.a_square) begin
        a_q <= prod;
      end
      if (cmd_i.b_shift) begin
        b_q <= {1'b0, b_q[DATA_WIDTH-1:1]};
      end
      if (cmd_i.acc_op == iia_pkg::ACC_DIVZ) begin
        st_q <= 1'b1;
      end
    end

    case (cmd_i.acc_op)
      iia_pkg::ACC_ADD:      acc_q <= a_q + b_q;
      iia_pkg::ACC_SUB:      acc_q <= a_q - b_q;
      iia_pkg::ACC_ZERO:     acc_q <= '0;
      iia_pkg::ACC_ONE:      acc_q <= DATA_WIDTH'(1);
      iia_pkg::ACC_ALL_ONES: acc_q <= '1;
      iia_pkg::ACC_PROD:     acc_q <= prod;
      iia_pkg::ACC_QUO: begin
        acc_q <= (a_q[DATA_WIDTH-1] ^ b_q[DATA_WIDTH-1]) ? ('0 - quo) : quo;
      end
      iia_pkg::ACC_REM:      acc_q <= a_q[DATA_WIDTH-1] ? ('0 - rem) : rem;
      iia_pkg::ACC_DIVZ:     acc_q <= '0;
      default:               acc_q <= acc_q;
    endcase

    case (cmd_i.cnt_op)
      iia_pkg::CNT_TWO: cnt_q <= DATA_WIDTH'(2);
      iia_pkg::CNT_INC: cnt_q <= cnt_q + DATA_WIDTH'(1);
      default:          cnt_q <= cnt_q;
    endcase
  end

  always_comb begin
    sts_o              = '0;
    sts_o.a_le_one     = a_q[DATA_WIDTH-1] || (a_q[DATA_WIDTH-1:1] == '0);
    sts_o.a_is_one     = (a_q == DATA_WIDTH'(1));
    sts_o.a_is_neg_one = &a_q;
    sts_o.b_zero       = (b_q == '0);
    sts_o.b_neg        = b_q[DATA_WIDTH-1];
    sts_o.b_odd        = b_q[0];
    sts_o.mul_done     = mul_done;
    sts_o.div_done     = div_done;
    sts_o.prime_stop   = (cnt_q > quo);
    sts_o.rem_zero     = (rem == '0);
    sts_o.prod_zero    = (prod == '0);
    sts_o.cnt_eq_a     = (cnt_q == a_q);
  end

  assign result_o = acc_q;
  assign status_o = st_q;

endmodule

`default_nettype wire

### rtl/core/iia_ctrl.sv
// ----------------------------------------------------------------------------
// Iterative integer ALU controller
// State machine that takes a beat, sequences the shared multiplier and
// divider where the selected operation needs them and hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module iia_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    opcode_i,
  input  wire logic          out_free_i,
  output logic               out_load_o,
  input  wire iia_pkg::sts_t sts_i,
  output iia_pkg::cmd_t      cmd_o
);

  iia_pkg::state_e state_q;
  iia_pkg::state_e state_d;
  iia_pkg::op_e    op_q;
  iia_pkg::op_e    op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iia_pkg::ST_IDLE;
      op_q    <= iia_pkg::OP_ADD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      iia_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = iia_pkg::op_e'(opcode_i);
          state_d    = iia_pkg::ST_DISPATCH;
        end
      end

      iia_pkg::ST_DISPATCH: begin
        unique case (op_q)
          iia_pkg::OP_ADD: begin
            cmd_o.acc_op = iia_pkg::ACC_ADD;
            state_d      = iia_pkg::ST_FINISH;
          end
          iia_pkg::OP_SUB: begin
            cmd_o.acc_op = iia_pkg::ACC_SUB;
            state_d      = iia_pkg::ST_FINISH;
          end
          iia_pkg::OP_MUL: begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_sel   = iia_pkg::MUL_A_B;
            state_d         = iia_pkg::ST_MUL_WAIT;
          end
          iia_pkg::OP_DIV, iia_pkg::OP_MOD: begin
            if (sts_i.b_zero) begin
              cmd_o.acc_op = iia_pkg::ACC_DIVZ;
              state_d      = iia_pkg::ST_FINISH;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = iia_pkg::DIV_B;
              state_d         = iia_pkg::ST_DIV_WAIT;
            end
          end
          iia_pkg::OP_PRIME: begin
            if (sts_i.a_le_one) begin
              cmd_o.acc_op = iia_pkg::ACC_ZERO;
              state_d      = iia_pkg::ST_FINISH;
            end else begin
              cmd_o.cnt_op = iia_pkg::CNT_TWO;
              state_d      = iia_pkg::ST_PRIME_START;
            end
          end
          iia_pkg::OP_FACT: begin
            cmd_o.acc_op = iia_pkg::ACC_ONE;
            if (sts_i.a_le_one) begin
              state_d = iia_pkg::ST_FINISH;
            end else begin
              cmd_o.cnt_op = iia_pkg::CNT_TWO;
              state_d      = iia_pkg::ST_FACT_START;
            end
          end
          default: begin
            if (sts_i.b_neg) begin
              if (sts_i.a_is_one) begin
                cmd_o.acc_op = iia_pkg::ACC_ONE;
              end else if (sts_i.a_is_neg_one) begin
                cmd_o.acc_op = sts_i.b_odd ? iia_pkg::ACC_ALL_ONES : iia_pkg::ACC_ONE;
              end else begin
                cmd_o.acc_op = iia_pkg::ACC_ZERO;
              end
              state_d = iia_pkg::ST_FINISH;
            end else begin
              cmd_o.acc_op = iia_pkg::ACC_ONE;
              state_d      = iia_pkg::ST_POW_CHECK;
            end
          end
        endcase
      end

      iia_pkg::ST_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_op = iia_pkg::ACC_PROD;
          state_d      = iia_pkg::ST_FINISH;
        end
      end

      iia_pkg::ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.acc_op = (op_q == iia_pkg::OP_DIV) ? iia_pkg::ACC_QUO : iia_pkg::ACC_REM;
          state_d      = iia_pkg::ST_FINISH;
        end
      end

      iia_pkg::ST_PRIME_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = iia_pkg::DIV_CNT;
        state_d         = iia_pkg::ST_PRIME_WAIT;
      end

      iia_pkg::ST_PRIME_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.prime_stop) begin
            cmd_o.acc_op = iia_pkg::ACC_ONE;
            state_d      = iia_pkg::ST_FINISH;
          end else if (sts_i.rem_zero) begin
            cmd_o.acc_op = iia_pkg::ACC_ZERO;
            state_d      = iia_pkg::ST_FINISH;
          end else begin
            cmd_o.cnt_op = iia_pkg::CNT_INC;
            state_d      = iia_pkg::ST_PRIME_START;
          end
        end
      end

      iia_pkg::ST_FACT_START: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = iia_pkg::MUL_ACC_CNT;
        state_d         = iia_pkg::ST_FACT_WAIT;
      end

      iia_pkg::ST_FACT_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_op = iia_pkg::ACC_PROD;
          if (sts_i.prod_zero || sts_i.cnt_eq_a) begin
            state_d = iia_pkg::ST_FINISH;
          end else begin
            cmd_o.cnt_op = iia_pkg::CNT_INC;
            state_d      = iia_pkg::ST_FACT_START;
          end
        end
      end

      iia_pkg::ST_POW_CHECK: begin
        if (sts_i.b_zero) begin
          state_d = iia_pkg::ST_FINISH;
        end else if (sts_i.b_odd) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = iia_pkg::MUL_ACC_A;
          state_d         = iia_pkg::ST_POW_MUL_WAIT;
        end else begin
          state_d = iia_pkg::ST_POW_SQ_START;
        end
      end

      iia_pkg::ST_POW_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_op = iia_pkg::ACC_PROD;
          state_d      = iia_pkg::ST_POW_SQ_START;
        end
      end

      iia_pkg::ST_POW_SQ_START: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = iia_pkg::MUL_A_A;
        state_d         = iia_pkg::ST_POW_SQ_WAIT;
      end

      iia_pkg::ST_POW_SQ_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.a_square = 1'b1;
          cmd_o.b_shift  = 1'b1;
          state_d        = iia_pkg::ST_POW_CHECK;
        end
      end

      iia_pkg::ST_FINISH: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = iia_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = iia_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/iterative_integer_alu.sv
// ----------------------------------------------------------------------------
// Iterative integer ALU: add and subtract need no iterative unit.
// Multiply and divide each run once on the shared units;
// prime, factorial and power repeat them a data-dependent number of times.
// One beat is in work at a time; the next can be accepted in the cycle after
// the result is loaded.
// Reset clears the controller and valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module iterative_integer_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            opcode_i,
  input  wire logic [DATA_WIDTH-1:0] operand_a_i,
  input  wire logic [DATA_WIDTH-1:0] operand_b_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0]      result_o,
  output logic                       status_o
);

  iia_pkg::cmd_t         cmd;
  iia_pkg::sts_t         sts;
  logic                  out_free;
  logic                  out_load;
  logic [DATA_WIDTH-1:0] dp_result;
  logic                  dp_status;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] result_q;
  logic                  status_q;

  assign out_free = !out_valid_q || out_ready_i;

  iia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iia_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (dp_result),
    .status_o    (dp_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= dp_result;
      status_q <= dp_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

  a_divz_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (result_o == '0))
    else $error("division by zero result is not zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without any work in progress");

endmodule

`default_nettype wire
